>>> rtl/core/box_average_downsampler_defines.svh
// Assertion macros shared by the box average downsampler modules.
// Needs aclk and aresetn in the scope of each use.
`ifndef BOX_AVERAGE_DOWNSAMPLER_DEFINES_SVH
`define BOX_AVERAGE_DOWNSAMPLER_DEFINES_SVH

// Same-cycle implication.
`define BOXDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BOXDS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/boxds_pkg.sv
`timescale 1ns / 1ps
// boxds_pkg: constants, beat payloads and internal control types for the
// box average downsampler. No dependencies.
package boxds_pkg;

    localparam int MAX_WIDTH    = 8192;
    localparam int MAX_CHANNELS = 3;
    localparam int MAX_FACTOR   = 16;
    localparam int HEIGHT_LIMIT = 8192;

    localparam int NUM_LANES  = 3;
    localparam int SAMPLE_W   = 16;
    localparam int DIM_W      = 14;
    localparam int FACT_W     = 5;
    localparam int CHAN_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;
    localparam int OUT_POS_W  = 13;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
    localparam int DIMC_W = COL_W + 1;
    localparam int DIMR_W = ROW_W + 1;
    localparam int FIF_W  = $clog2(MAX_FACTOR + 1);
    localparam int PSUM_W = SAMPLE_W + $clog2(MAX_FACTOR);
    localparam int PCNT_W = $clog2(MAX_FACTOR + 1);
    localparam int BSUM_W = SAMPLE_W + 2 * $clog2(MAX_FACTOR);
    localparam int BCNT_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int STEP_W = $clog2(SAMPLE_W + 1);

    localparam logic [DIM_W-1:0]  RST_WIDTH    = DIM_W'(1);
    localparam logic [DIM_W-1:0]  RST_HEIGHT   = DIM_W'(1);
    localparam logic [FACT_W-1:0] RST_FACTOR   = FACT_W'(4);
    localparam logic [CHAN_W-1:0] RST_CHANNELS = CHAN_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_FACTOR   = 2'd2,
        CFG_CHANNELS = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_DIV
    } ctrl_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_ch0;
        logic [SAMPLE_W-1:0] sample_ch1;
        logic [SAMPLE_W-1:0] sample_ch2;
        logic                valid_ch0;
        logic                valid_ch1;
        logic                valid_ch2;
    } in_beat_t;

    typedef struct packed {
        logic [OUT_POS_W-1:0] out_col;
        logic [OUT_POS_W-1:0] out_row;
        logic [SAMPLE_W-1:0]  avg_ch0;
        logic [SAMPLE_W-1:0]  avg_ch1;
        logic [SAMPLE_W-1:0]  avg_ch2;
        logic                 frame_last;
    } out_beat_t;

    typedef struct packed {
        logic [DIMC_W-1:0] w_eff;
        logic [DIMR_W-1:0] h_eff;
        logic [FACT_W-1:0] f_eff;
    } geom_t;

    typedef struct packed {
        logic             in_range;
        logic             blk_first;
        logic             col_last;
        logic             band_first;
        logic             row_last;
        logic             frame_last;
        logic [COL_W-1:0] bx;
        logic [ROW_W-1:0] by;
    } pos_info_t;

    typedef struct packed {
        logic [BCNT_W-1:0] cnt;
        logic [BSUM_W-1:0] sum;
    } lane_acc_t;

    typedef lane_acc_t [NUM_LANES-1:0]             acc_word_t;
    typedef logic [NUM_LANES-1:0][BSUM_W-1:0]   bsum_vec_t;
    typedef logic [NUM_LANES-1:0][BCNT_W-1:0]   bcnt_vec_t;
    typedef logic [NUM_LANES-1:0][SAMPLE_W-1:0] avg_vec_t;

endpackage

>>> rtl/core/boxds_ram.sv
`timescale 1ns / 1ps
// boxds_ram: simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
module boxds_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/boxds_pos.sv
`timescale 1ns / 1ps
// boxds_pos: raster position and block bookkeeping for the input stream.
// Depends on boxds_pkg.
module boxds_pos (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  restart,
    input  logic                  advance,
    input  boxds_pkg::geom_t      geom,
    output boxds_pkg::pos_info_t  info
);

    logic [boxds_pkg::COL_W-1:0] col_reg, col_next;
    logic [boxds_pkg::COL_W-1:0] bx_reg, bx_next;
    logic [boxds_pkg::COL_W-1:0] cbase_reg, cbase_next;
    logic [boxds_pkg::FIF_W-1:0] cif_reg, cif_next;
    logic [boxds_pkg::ROW_W-1:0] row_reg, row_next;
    logic [boxds_pkg::ROW_W-1:0] by_reg, by_next;
    logic [boxds_pkg::ROW_W-1:0] rbase_reg, rbase_next;
    logic [boxds_pkg::FIF_W-1:0] rif_reg, rif_next;

    logic [boxds_pkg::DIMC_W-1:0] cend;
    logic [boxds_pkg::DIMC_W:0]   cend2;
    logic [boxds_pkg::DIMR_W-1:0] rend;
    logic [boxds_pkg::DIMR_W:0]   rend2;
    logic [boxds_pkg::FIF_W-1:0]  fif_last;
    logic col_at_end, row_at_end, cif_at_end, rif_at_end;
    logic col_ok, row_ok;

    always_comb begin
        fif_last   = boxds_pkg::FIF_W'(geom.f_eff - boxds_pkg::FACT_W'(1));
        cend       = boxds_pkg::DIMC_W'(cbase_reg) + boxds_pkg::DIMC_W'(geom.f_eff);
        cend2      = {1'b0, cend} + (boxds_pkg::DIMC_W + 1)'(geom.f_eff);
        rend       = boxds_pkg::DIMR_W'(rbase_reg) + boxds_pkg::DIMR_W'(geom.f_eff);
        rend2      = {1'b0, rend} + (boxds_pkg::DIMR_W + 1)'(geom.f_eff);
        col_at_end = ({1'b0, col_reg} == geom.w_eff - boxds_pkg::DIMC_W'(1));
        row_at_end = ({1'b0, row_reg} == geom.h_eff - boxds_pkg::DIMR_W'(1));
        cif_at_end = (cif_reg == fif_last);
        rif_at_end = (rif_reg == fif_last);
        // A partial block exists only when the image is narrower than one block.
        col_ok     = (cend <= geom.w_eff) || (bx_reg == '0);
        row_ok     = (rend <= geom.h_eff) || (by_reg == '0);

        info.in_range   = col_ok && row_ok;
        info.blk_first  = (cif_reg == '0);
        info.col_last   = cif_at_end || col_at_end;
        info.band_first = (rif_reg == '0);
        info.row_last   = rif_at_end || row_at_end;
        info.frame_last = (cend2 > {1'b0, geom.w_eff}) && (rend2 > {1'b0, geom.h_eff});
        info.bx         = bx_reg;
        info.by         = by_reg;
    end

    always_comb begin
        col_next   = col_reg;
        bx_next    = bx_reg;
        cbase_next = cbase_reg;
        cif_next   = cif_reg;
        row_next   = row_reg;
        by_next    = by_reg;
        rbase_next = rbase_reg;
        rif_next   = rif_reg;
        if (advance) begin
            if (col_at_end) begin
                col_next   = '0;
                bx_next    = '0;
                cbase_next = '0;
                cif_next   = '0;
                if (row_at_end) begin
                    row_next   = '0;
                    by_next    = '0;
                    rbase_next = '0;
                    rif_next   = '0;
                end else begin
                    row_next = row_reg + boxds_pkg::ROW_W'(1);
                    if (rif_at_end) begin
                        rif_next   = '0;
                        by_next    = by_reg + boxds_pkg::ROW_W'(1);
                        rbase_next = rbase_reg + boxds_pkg::ROW_W'(geom.f_eff);
                    end else begin
                        rif_next = rif_reg + boxds_pkg::FIF_W'(1);
                    end
                end
            end else begin
                col_next = col_reg + boxds_pkg::COL_W'(1);
                if (cif_at_end) begin
                    cif_next   = '0;
                    bx_next    = bx_reg + boxds_pkg::COL_W'(1);
                    cbase_next = cbase_reg + boxds_pkg::COL_W'(geom.f_eff);
                end else begin
                    cif_next = cif_reg + boxds_pkg::FIF_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg   <= '0;
            bx_reg    <= '0;
            cbase_reg <= '0;
            cif_reg   <= '0;
            row_reg   <= '0;
            by_reg    <= '0;
            rbase_reg <= '0;
            rif_reg   <= '0;
        end else begin
            col_reg   <= col_next;
            bx_reg    <= bx_next;
            cbase_reg <= cbase_next;
            cif_reg   <= cif_next;
            row_reg   <= row_next;
            by_reg    <= by_next;
            rbase_reg <= rbase_next;
            rif_reg   <= rif_next;
        end
    end

endmodule

>>> rtl/core/boxds_div.sv
`timescale 1ns / 1ps
// boxds_div: three-lane restoring divider, one quotient bit per cycle.
// Depends on boxds_pkg and box_average_downsampler_defines.svh.
`include "box_average_downsampler_defines.svh"
module boxds_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  boxds_pkg::bsum_vec_t  dividend,
    input  boxds_pkg::bcnt_vec_t  divisor,
    output logic                  busy,
    output boxds_pkg::avg_vec_t   quotient
);

    logic                                busy_reg, busy_next;
    logic [boxds_pkg::STEP_W-1:0]        step_reg, step_next;
    boxds_pkg::bcnt_vec_t                rem_reg, rem_next;
    boxds_pkg::bcnt_vec_t                dsr_reg, dsr_next;
    boxds_pkg::avg_vec_t                 quo_reg, quo_next;
    logic [boxds_pkg::NUM_LANES-1:0]     zero_reg, zero_next;

    always_comb begin
        logic [boxds_pkg::BCNT_W:0] trial;
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        zero_next = zero_reg;
        trial     = '0;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            for (int i = 0; i < boxds_pkg::NUM_LANES; i++) begin
                // Quotient fits the sample width, so the top bits start as remainder.
                rem_next[i]  = boxds_pkg::BCNT_W'(dividend[i] >> boxds_pkg::SAMPLE_W);
                quo_next[i]  = dividend[i][boxds_pkg::SAMPLE_W-1:0];
                dsr_next[i]  = divisor[i];
                zero_next[i] = (divisor[i] == '0);
            end
        end else if (busy_reg) begin
            for (int i = 0; i < boxds_pkg::NUM_LANES; i++) begin
                trial = {rem_reg[i], quo_reg[i][boxds_pkg::SAMPLE_W-1]};
                if (trial >= {1'b0, dsr_reg[i]}) begin
                    rem_next[i] = boxds_pkg::BCNT_W'(trial - {1'b0, dsr_reg[i]});
                    quo_next[i] = {quo_reg[i][boxds_pkg::SAMPLE_W-2:0], 1'b1};
                end else begin
                    rem_next[i] = trial[boxds_pkg::BCNT_W-1:0];
                    quo_next[i] = {quo_reg[i][boxds_pkg::SAMPLE_W-2:0], 1'b0};
                end
            end
            if (step_reg == boxds_pkg::STEP_W'(boxds_pkg::SAMPLE_W - 1)) begin
                busy_next = 1'b0;
                step_next = '0;
            end else begin
                step_next = step_reg + boxds_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quo_reg  <= quo_next;
        zero_reg <= zero_next;
    end

    always_comb begin
        busy = busy_reg;
        for (int i = 0; i < boxds_pkg::NUM_LANES; i++) begin
            quotient[i] = zero_reg[i] ? '0 : quo_reg[i];
        end
    end

    `BOXDS_ASSERT_IMP(a_start_when_idle, start, !busy_reg, "divider restarted while busy")
    `BOXDS_ASSERT_NXT(a_start_runs, start, busy_reg, "divider did not start")
    `BOXDS_ASSERT_IMP(a_idle_step_clear, !busy_reg, step_reg == '0, "step count left over")

endmodule

>>> rtl/core/box_average_downsampler.sv
`timescale 1ns / 1ps
// box_average_downsampler: top level, configuration, control and datapath.
// Depends on boxds_pkg, boxds_pos, boxds_ram, boxds_div and the defines header.
//
// Usage:
//   s_* takes full-resolution pixels in raster order, one beat per pixel with
//   three samples and their finite flags. m_* gives one beat per averaged
//   block: block column/row, three truncated averages, frame_last on the last.
//   cfg_* writes image_width, image_height, down_factor, channel_count by
//   index; any write restarts the frame at column 0, row 0. Write only while
//   the block is idle; a waiting cfg beat holds s_ready low.
//   Throughput: s_ready drops after the last pixel of a block's row segment
//   (read-modify-write of the block-column memory) and after the pixel that
//   closes a block: merge, bit-serial divider, output load. Its result goes
//   from the merge state through the divider to the output register.
//   A pending result sits in the output register while pixels keep flowing;
//   if m_ready stays low, the next block result waits and s_ready drops.
//   Reset restores the default registers and the start of a frame; the
//   memory needs no clearing pass, the first row of each band overwrites it.
`include "box_average_downsampler_defines.svh"
module box_average_downsampler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  boxds_pkg::in_beat_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output boxds_pkg::out_beat_t              m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [boxds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [boxds_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [boxds_pkg::DIM_W-1:0]  width_reg;
    logic [boxds_pkg::DIM_W-1:0]  height_reg;
    logic [boxds_pkg::FACT_W-1:0] factor_reg;
    logic [boxds_pkg::CHAN_W-1:0] chan_reg;

    boxds_pkg::geom_t             geom;
    logic [boxds_pkg::CHAN_W-1:0] nch_eff;
    boxds_pkg::pos_info_t         info;

    boxds_pkg::ctrl_state_t state_reg, state_next;
    logic s_fire, cfg_fire, blk_fire, out_load;
    logic in_merge, in_div, div_hold;

    logic [boxds_pkg::NUM_LANES-1:0][boxds_pkg::PSUM_W-1:0] psum_reg, psum_next;
    logic [boxds_pkg::NUM_LANES-1:0][boxds_pkg::PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic [boxds_pkg::SAMPLE_W-1:0] smp [boxds_pkg::NUM_LANES];
    logic [boxds_pkg::NUM_LANES-1:0] flag;
    logic [boxds_pkg::NUM_LANES-1:0] lane_vld;

    logic                         band_first_reg, row_last_reg, frame_last_reg;
    logic [boxds_pkg::COL_W-1:0]  bx_reg;
    logic [boxds_pkg::ROW_W-1:0]  by_reg;

    logic                          ram_wr_en, ram_rd_en;
    logic [$bits(boxds_pkg::acc_word_t)-1:0] ram_rd_data;
    boxds_pkg::acc_word_t          acc_rd, merged;

    logic                          div_start, div_busy;
    boxds_pkg::bsum_vec_t          div_num;
    boxds_pkg::bcnt_vec_t          div_den;
    boxds_pkg::avg_vec_t           div_quo;

    logic                          m_valid_reg, m_valid_next;
    boxds_pkg::out_beat_t          m_data_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= boxds_pkg::RST_WIDTH;
            height_reg <= boxds_pkg::RST_HEIGHT;
            factor_reg <= boxds_pkg::RST_FACTOR;
            chan_reg   <= boxds_pkg::RST_CHANNELS;
        end else if (cfg_fire) begin
            case (boxds_pkg::cfg_idx_t'(cfg_index))
                boxds_pkg::CFG_WIDTH:    width_reg  <= cfg_data[boxds_pkg::DIM_W-1:0];
                boxds_pkg::CFG_HEIGHT:   height_reg <= cfg_data[boxds_pkg::DIM_W-1:0];
                boxds_pkg::CFG_FACTOR:   factor_reg <= cfg_data[boxds_pkg::FACT_W-1:0];
                boxds_pkg::CFG_CHANNELS: chan_reg   <= cfg_data[boxds_pkg::CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            geom.w_eff = boxds_pkg::DIMC_W'(1);
        end else if (32'(width_reg) > boxds_pkg::MAX_WIDTH) begin
            geom.w_eff = boxds_pkg::DIMC_W'(boxds_pkg::MAX_WIDTH);
        end else begin
            geom.w_eff = boxds_pkg::DIMC_W'(width_reg);
        end
        if (height_reg == '0) begin
            geom.h_eff = boxds_pkg::DIMR_W'(1);
        end else if (32'(height_reg) > boxds_pkg::HEIGHT_LIMIT) begin
            geom.h_eff = boxds_pkg::DIMR_W'(boxds_pkg::HEIGHT_LIMIT);
        end else begin
            geom.h_eff = boxds_pkg::DIMR_W'(height_reg);
        end
        if (factor_reg == '0) begin
            geom.f_eff = boxds_pkg::FACT_W'(1);
        end else if (32'(factor_reg) > boxds_pkg::MAX_FACTOR) begin
            geom.f_eff = boxds_pkg::FACT_W'(boxds_pkg::MAX_FACTOR);
        end else begin
            geom.f_eff = factor_reg;
        end
        if (chan_reg == '0) begin
            nch_eff = boxds_pkg::CHAN_W'(1);
        end else if (32'(chan_reg) > boxds_pkg::MAX_CHANNELS) begin
            nch_eff = boxds_pkg::CHAN_W'(boxds_pkg::MAX_CHANNELS);
        end else begin
            nch_eff = chan_reg;
        end
    end

    boxds_pos u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_fire),
        .advance (s_fire),
        .geom    (geom),
        .info    (info)
    );

    // control
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cfg_ready  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            boxds_pkg::ST_IDLE: begin
                s_ready   = !cfg_valid;
                cfg_ready = 1'b1;
                if (s_valid && !cfg_valid && info.in_range && info.col_last) begin
                    state_next = boxds_pkg::ST_MERGE;
                end
            end
            boxds_pkg::ST_MERGE: begin
                state_next = row_last_reg ? boxds_pkg::ST_DIV : boxds_pkg::ST_IDLE;
            end
            boxds_pkg::ST_DIV: begin
                if (!div_busy && (!m_valid_reg || m_ready)) begin
                    out_load   = 1'b1;
                    state_next = boxds_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = boxds_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_fire   = s_valid && s_ready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign blk_fire = s_fire && info.in_range && info.col_last;
    assign in_merge = (state_reg == boxds_pkg::ST_MERGE);
    assign in_div   = (state_reg == boxds_pkg::ST_DIV);
    assign div_hold = in_div && m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= boxds_pkg::ST_IDLE;
            row_last_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (blk_fire) begin
                row_last_reg <= info.row_last;
            end
        end
    end

    // row segment accumulation
    always_comb begin
        smp[0]  = s_data.sample_ch0;
        smp[1]  = s_data.sample_ch1;
        smp[2]  = s_data.sample_ch2;
        flag[0] = s_data.valid_ch0;
        flag[1] = s_data.valid_ch1;
        flag[2] = s_data.valid_ch2;
        psum_next = psum_reg;
        pcnt_next = pcnt_reg;
        for (int i = 0; i < boxds_pkg::NUM_LANES; i++) begin
            lane_vld[i] = flag[i] && (boxds_pkg::CHAN_W'(i) < nch_eff);
            if (s_fire && info.in_range) begin
                psum_next[i] = (info.blk_first ? '0 : psum_reg[i])
                             + (lane_vld[i] ? boxds_pkg::PSUM_W'(smp[i]) : '0);
                pcnt_next[i] = (info.blk_first ? '0 : pcnt_reg[i])
                             + boxds_pkg::PCNT_W'(lane_vld[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        psum_reg <= psum_next;
        pcnt_reg <= pcnt_next;
        if (blk_fire) begin
            band_first_reg <= info.band_first;
            frame_last_reg <= info.frame_last;
            bx_reg         <= info.bx;
            by_reg         <= info.by;
        end
    end

    // block-column memory: read on the segment's last pixel, merge and write
    // back next cycle; the state machine keeps reads out of the merge cycle
    assign ram_rd_en = blk_fire;
    assign ram_wr_en = in_merge && !row_last_reg;
    assign acc_rd    = boxds_pkg::acc_word_t'(ram_rd_data);

    always_comb begin
        for (int i = 0; i < boxds_pkg::NUM_LANES; i++) begin
            merged[i].sum = (band_first_reg ? '0 : acc_rd[i].sum)
                          + boxds_pkg::BSUM_W'(psum_reg[i]);
            merged[i].cnt = (band_first_reg ? '0 : acc_rd[i].cnt)
                          + boxds_pkg::BCNT_W'(pcnt_reg[i]);
            div_num[i]    = merged[i].sum;
            div_den[i]    = merged[i].cnt;
        end
    end

    boxds_ram #(
        .WIDTH ($bits(boxds_pkg::acc_word_t)),
        .DEPTH (boxds_pkg::MAX_WIDTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (bx_reg),
        .wr_data (merged),
        .rd_en   (ram_rd_en),
        .rd_addr (info.bx),
        .rd_data (ram_rd_data)
    );

    assign div_start = in_merge && row_last_reg;

    boxds_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.out_col    <= boxds_pkg::OUT_POS_W'(bx_reg);
            m_data_reg.out_row    <= boxds_pkg::OUT_POS_W'(by_reg);
            m_data_reg.avg_ch0    <= div_quo[0];
            m_data_reg.avg_ch1    <= div_quo[1];
            m_data_reg.avg_ch2    <= div_quo[2];
            m_data_reg.frame_last <= frame_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BOXDS_ASSERT_NXT(a_seg_end_merges, blk_fire, in_merge, "segment end did not merge")
    `BOXDS_ASSERT_IMP(a_ram_no_overlap, ram_wr_en, !ram_rd_en, "memory read during write-back")
    `BOXDS_ASSERT_NXT(a_result_not_lost, div_hold, in_div, "pending result overwritten")

endmodule
